// ===== src/dpcr_pkg.sv =====
// Shared types, constants and rounding helpers for the disc pair collision unit.
// No dependencies; every other file imports this package.
package dpcr_pkg;

    localparam int SQRT_STEPS          = 33;
    localparam int DIV_STEPS           = 31;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam logic [15:0]        RESTITUTION_RESET = 16'd32768;
    localparam logic [16:0]        ONE_Q15           = 17'd32768;
    localparam logic signed [35:0] DV_LIMIT          = 36'sd17179869183;

    typedef struct packed {
        logic signed [31:0] first_pos_x;
        logic signed [31:0] first_pos_y;
        logic signed [31:0] first_vel_x;
        logic signed [31:0] first_vel_y;
        logic        [30:0] first_radius;
        logic        [15:0] first_mass;
        logic signed [31:0] second_pos_x;
        logic signed [31:0] second_pos_y;
        logic signed [31:0] second_vel_x;
        logic signed [31:0] second_vel_y;
        logic        [30:0] second_radius;
        logic        [15:0] second_mass;
    } in_t;

    typedef struct packed {
        logic               touching;
        logic signed [31:0] out_first_pos_x;
        logic signed [31:0] out_first_pos_y;
        logic signed [31:0] out_first_vel_x;
        logic signed [31:0] out_first_vel_y;
        logic signed [31:0] out_second_pos_x;
        logic signed [31:0] out_second_pos_y;
        logic signed [31:0] out_second_vel_x;
        logic signed [31:0] out_second_vel_y;
    } out_t;

    // classified pair, front to back
    typedef struct packed {
        in_t         item;
        logic        dx_neg;
        logic        dy_neg;
        logic [32:0] ax;
        logic [32:0] ay;
        logic [65:0] ssq;
        logic [31:0] rsum;
        logic        touching;
        logic        coinc;
        logic        massless;
    } cls_t;

    // round to nearest, ties away from zero, of p / 2^sh
    function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] p,
                                                     input int unsigned sh);
        logic [67:0] m;
        logic [67:0] r;
        m = p[67] ? 68'(-p) : 68'(p);
        r = (m + (68'd1 << (sh - 1))) >> sh;
        return p[67] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        logic signed [31:0] r;
        if (x > 68'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < -68'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = $signed(x[31:0]);
        end
        return r;
    endfunction

endpackage

// ===== src/dpcr_front.sv =====
// Front end: accepts pair beats, forms centre deltas, squared distance and touch test.
// Depends on dpcr_pkg.
module dpcr_front import dpcr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic pair_valid,
    output logic pair_ready,
    input  in_t  pair_data,
    output logic push_valid,
    input  logic push_ready,
    output cls_t push_data
);

    logic en;

    logic        a_vld_reg;
    in_t         a_item_reg;
    logic        a_dx_neg_reg, a_dy_neg_reg, a_massless_reg;
    logic [32:0] a_ax_reg, a_ay_reg;
    logic [31:0] a_rsum_reg;

    logic        b_vld_reg;
    in_t         b_item_reg;
    logic        b_dx_neg_reg, b_dy_neg_reg, b_massless_reg;
    logic [32:0] b_ax_reg, b_ay_reg;
    logic [31:0] b_rsum_reg;
    logic [64:0] b_sqx_reg, b_sqy_reg;
    logic [63:0] b_rsq_reg;

    logic c_vld_reg;
    cls_t c_data_reg;

    logic signed [32:0] dx_next, dy_next;
    logic        [32:0] ax_next, ay_next;
    logic        [65:0] ssq_next;

    assign en         = !c_vld_reg || push_ready;
    assign pair_ready = en;
    assign push_valid = c_vld_reg;
    assign push_data  = c_data_reg;

    assign dx_next = {pair_data.second_pos_x[31], pair_data.second_pos_x}
                   - {pair_data.first_pos_x[31], pair_data.first_pos_x};
    assign dy_next = {pair_data.second_pos_y[31], pair_data.second_pos_y}
                   - {pair_data.first_pos_y[31], pair_data.first_pos_y};
    assign ax_next = dx_next[32] ? 33'(-dx_next) : 33'(dx_next);
    assign ay_next = dy_next[32] ? 33'(-dy_next) : 33'(dy_next);
    assign ssq_next = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= pair_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg     <= pair_data;
            a_dx_neg_reg   <= dx_next[32];
            a_dy_neg_reg   <= dy_next[32];
            a_ax_reg       <= ax_next;
            a_ay_reg       <= ay_next;
            a_rsum_reg     <= {1'b0, pair_data.first_radius} + {1'b0, pair_data.second_radius};
            a_massless_reg <= (pair_data.first_mass == 16'd0) && (pair_data.second_mass == 16'd0);

            b_item_reg     <= a_item_reg;
            b_dx_neg_reg   <= a_dx_neg_reg;
            b_dy_neg_reg   <= a_dy_neg_reg;
            b_ax_reg       <= a_ax_reg;
            b_ay_reg       <= a_ay_reg;
            b_rsum_reg     <= a_rsum_reg;
            b_massless_reg <= a_massless_reg;
            b_sqx_reg      <= 65'(a_ax_reg * a_ax_reg);
            b_sqy_reg      <= 65'(a_ay_reg * a_ay_reg);
            b_rsq_reg      <= a_rsum_reg * a_rsum_reg;

            c_data_reg.item     <= b_item_reg;
            c_data_reg.dx_neg   <= b_dx_neg_reg;
            c_data_reg.dy_neg   <= b_dy_neg_reg;
            c_data_reg.ax       <= b_ax_reg;
            c_data_reg.ay       <= b_ay_reg;
            c_data_reg.ssq      <= ssq_next;
            c_data_reg.rsum     <= b_rsum_reg;
            c_data_reg.touching <= ssq_next <= {2'b00, b_rsq_reg};
            c_data_reg.coinc    <= ssq_next == 66'd0;
            c_data_reg.massless <= b_massless_reg;
        end
    end

endmodule

// ===== src/dpcr_queue.sv =====
// Short queue of classified pairs between front and back.
// Depends on dpcr_pkg.
module dpcr_queue import dpcr_pkg::*; #(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cls_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cls_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cls_t          mem_reg [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/dpcr_back.sv =====
// Back end: pipelined square root, four dividers, then the position and velocity response.
// Depends on dpcr_pkg.
module dpcr_back import dpcr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] restitution,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  cls_t        pop_data,
    output logic        resp_valid,
    input  logic        resp_ready,
    output out_t        resp_data
);

    typedef struct packed {
        in_t         item;
        logic        touching;
        logic        coinc;
        logic        massless;
        logic        dx_neg;
        logic        dy_neg;
        logic [31:0] rsum;
    } ctx_t;

    logic en;
    logic out_vld_reg;
    out_t out_data_reg;

    assign en         = !out_vld_reg || resp_ready;
    assign pop_ready  = en;
    assign resp_valid = out_vld_reg;
    assign resp_data  = out_data_reg;

    // ---------------- square root, one result bit per stage
    logic        sq_vld_reg  [0:SQRT_STEPS];
    ctx_t        sq_ctx_reg  [0:SQRT_STEPS];
    logic [34:0] sq_rem_reg  [0:SQRT_STEPS];
    logic [32:0] sq_root_reg [0:SQRT_STEPS];
    logic [65:0] sq_rad_reg  [0:SQRT_STEPS];
    logic [32:0] sq_ax_reg   [0:SQRT_STEPS];
    logic [32:0] sq_ay_reg   [0:SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg[0] <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_ctx_reg[0].item     <= pop_data.item;
            sq_ctx_reg[0].touching <= pop_data.touching;
            sq_ctx_reg[0].coinc    <= pop_data.coinc;
            sq_ctx_reg[0].massless <= pop_data.massless;
            sq_ctx_reg[0].dx_neg   <= pop_data.dx_neg;
            sq_ctx_reg[0].dy_neg   <= pop_data.dy_neg;
            sq_ctx_reg[0].rsum     <= pop_data.rsum;
            sq_rem_reg[0]          <= '0;
            sq_root_reg[0]         <= '0;
            sq_rad_reg[0]          <= pop_data.ssq;
            sq_ax_reg[0]           <= pop_data.ax;
            sq_ay_reg[0]           <= pop_data.ay;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        logic [36:0] rt, trial;
        logic        ge;

        assign rt    = {sq_rem_reg[j], sq_rad_reg[j][65:64]};
        assign trial = {2'b00, sq_root_reg[j], 2'b01};
        assign ge    = rt >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_vld_reg[j+1] <= sq_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_ctx_reg[j+1]  <= sq_ctx_reg[j];
                sq_rem_reg[j+1]  <= ge ? 35'(rt - trial) : rt[34:0];
                sq_root_reg[j+1] <= {sq_root_reg[j][31:0], ge};
                sq_rad_reg[j+1]  <= {sq_rad_reg[j][63:0], 2'b00};
                sq_ax_reg[j+1]   <= sq_ax_reg[j];
                sq_ay_reg[j+1]   <= sq_ay_reg[j];
            end
        end
    end

    // ---------------- dividers: lanes ux, uy, f1, f2; one quotient bit per stage
    logic        dv_vld_reg  [0:DIV_STEPS];
    ctx_t        dv_ctx_reg  [0:DIV_STEPS];
    logic [32:0] dv_dist_reg [0:DIV_STEPS];
    logic [16:0] dv_msum_reg [0:DIV_STEPS];
    logic [32:0] dv_rem_reg  [0:DIV_STEPS][0:3];
    logic [30:0] dv_low_reg  [0:DIV_STEPS][0:3];
    logic [30:0] dv_q_reg    [0:DIV_STEPS][0:3];

    logic [16:0] num;
    logic [32:0] prod_m1, prod_m2;
    ctx_t        sq_last;

    assign sq_last = sq_ctx_reg[SQRT_STEPS];
    assign num     = ONE_Q15 + {1'b0, restitution};
    assign prod_m1 = sq_last.item.first_mass * num;
    assign prod_m2 = sq_last.item.second_mass * num;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_vld_reg[0] <= sq_vld_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_ctx_reg[0]    <= sq_last;
            dv_dist_reg[0]   <= sq_root_reg[SQRT_STEPS];
            dv_msum_reg[0]   <= {1'b0, sq_last.item.first_mass}
                              + {1'b0, sq_last.item.second_mass};
            dv_rem_reg[0][0] <= {1'b0, sq_ax_reg[SQRT_STEPS][32:1]};
            dv_low_reg[0][0] <= {sq_ax_reg[SQRT_STEPS][0], 30'd0};
            dv_rem_reg[0][1] <= {1'b0, sq_ay_reg[SQRT_STEPS][32:1]};
            dv_low_reg[0][1] <= {sq_ay_reg[SQRT_STEPS][0], 30'd0};
            // factor numerators are mass * (2^15 + restitution) * 2^14
            dv_rem_reg[0][2] <= {17'd0, prod_m2[32:17]};
            dv_low_reg[0][2] <= {prod_m2[16:0], 14'd0};
            dv_rem_reg[0][3] <= {17'd0, prod_m1[32:17]};
            dv_low_reg[0][3] <= {prod_m1[16:0], 14'd0};
            for (int k = 0; k < 4; k++)
            begin
                dv_q_reg[0][k] <= '0;
            end
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_ctx_reg[j+1]  <= dv_ctx_reg[j];
                dv_dist_reg[j+1] <= dv_dist_reg[j];
                dv_msum_reg[j+1] <= dv_msum_reg[j];
            end
        end

        for (genvar k = 0; k < 4; k++)
        begin : g_lane
            logic [33:0] rt, dvs;
            logic        ge;

            assign dvs = (k < 2) ? {1'b0, dv_dist_reg[j]} : {17'd0, dv_msum_reg[j]};
            assign rt  = {dv_rem_reg[j][k], dv_low_reg[j][k][30]};
            assign ge  = rt >= dvs;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[j+1][k] <= ge ? 33'(rt - dvs) : rt[32:0];
                    dv_low_reg[j+1][k] <= {dv_low_reg[j][k][29:0], 1'b0};
                    dv_q_reg[j+1][k]   <= {dv_q_reg[j][k][29:0], ge};
                end
            end
        end
    end

    // ---------------- response stages
    ctx_t               dv_last;
    logic signed [31:0] ux_next, uy_next;
    logic signed [33:0] corr2_next;

    assign dv_last    = dv_ctx_reg[DIV_STEPS];
    assign ux_next    = dv_last.dx_neg ? -$signed({1'b0, dv_q_reg[DIV_STEPS][0]})
                                       : $signed({1'b0, dv_q_reg[DIV_STEPS][0]});
    assign uy_next    = dv_last.dy_neg ? -$signed({1'b0, dv_q_reg[DIV_STEPS][1]})
                                       : $signed({1'b0, dv_q_reg[DIV_STEPS][1]});
    assign corr2_next = $signed({2'b00, dv_last.rsum}) - $signed({1'b0, dv_dist_reg[DIV_STEPS]});

    logic               m_vld_reg [1:7];
    ctx_t               m_ctx_reg [1:7];

    logic signed [31:0] m1_ux_reg, m1_uy_reg;
    logic        [30:0] m1_f1_reg, m1_f2_reg;
    logic signed [65:0] m1_px_reg, m1_py_reg;
    logic signed [63:0] m1_a1_reg, m1_b1_reg, m1_a2_reg, m1_b2_reg;

    logic signed [31:0] m2_ux_reg, m2_uy_reg;
    logic        [30:0] m2_f1_reg, m2_f2_reg;
    logic signed [33:0] m2_sx_reg, m2_sy_reg;
    logic signed [64:0] m2_sum1_reg, m2_sum2_reg;

    logic signed [31:0] m3_ux_reg, m3_uy_reg;
    logic        [30:0] m3_f1_reg, m3_f2_reg;
    logic signed [34:0] m3_np1x_reg, m3_np1y_reg, m3_np2x_reg, m3_np2y_reg;
    logic signed [34:0] m3_n1_reg, m3_n2_reg;

    logic signed [31:0] m4_ux_reg, m4_uy_reg;
    logic        [30:0] m4_f1_reg, m4_f2_reg;
    logic signed [34:0] m4_np1x_reg, m4_np1y_reg, m4_np2x_reg, m4_np2y_reg;
    logic signed [35:0] m4_diff_reg, m4_diffn_reg;

    logic signed [31:0] m5_ux_reg, m5_uy_reg;
    logic signed [34:0] m5_np1x_reg, m5_np1y_reg, m5_np2x_reg, m5_np2y_reg;
    logic signed [67:0] m5_pr1_reg, m5_pr2_reg;

    logic signed [31:0] m6_ux_reg, m6_uy_reg;
    logic signed [34:0] m6_np1x_reg, m6_np1y_reg, m6_np2x_reg, m6_np2y_reg;
    logic signed [35:0] m6_d1_reg, m6_d2_reg;

    logic signed [34:0] m7_np1x_reg, m7_np1y_reg, m7_np2x_reg, m7_np2y_reg;
    logic signed [67:0] m7_q1x_reg, m7_q1y_reg, m7_q2x_reg, m7_q2y_reg;

    logic signed [67:0] r1_next, r2_next;
    logic signed [35:0] d1_next, d2_next;

    assign r1_next = rnd_shift(m5_pr1_reg, 29);
    assign r2_next = rnd_shift(m5_pr2_reg, 29);
    assign d1_next = (r1_next > 68'(DV_LIMIT)) ? DV_LIMIT :
                     (r1_next < -68'(DV_LIMIT)) ? -DV_LIMIT : 36'(r1_next);
    assign d2_next = (r2_next > 68'(DV_LIMIT)) ? DV_LIMIT :
                     (r2_next < -68'(DV_LIMIT)) ? -DV_LIMIT : 36'(r2_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 7; i++)
            begin
                m_vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg[1] <= dv_vld_reg[DIV_STEPS];
            for (int i = 2; i <= 7; i++)
            begin
                m_vld_reg[i] <= m_vld_reg[i-1];
            end
            out_vld_reg <= m_vld_reg[7];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_ctx_reg[1] <= dv_last;
            for (int i = 2; i <= 7; i++)
            begin
                m_ctx_reg[i] <= m_ctx_reg[i-1];
            end

            // products along the centre line
            m1_ux_reg <= ux_next;
            m1_uy_reg <= uy_next;
            m1_f1_reg <= dv_q_reg[DIV_STEPS][2];
            m1_f2_reg <= dv_q_reg[DIV_STEPS][3];
            m1_px_reg <= ux_next * corr2_next;
            m1_py_reg <= uy_next * corr2_next;
            m1_a1_reg <= dv_last.item.first_vel_x * ux_next;
            m1_b1_reg <= dv_last.item.first_vel_y * uy_next;
            m1_a2_reg <= dv_last.item.second_vel_x * ux_next;
            m1_b2_reg <= dv_last.item.second_vel_y * uy_next;

            m2_ux_reg   <= m1_ux_reg;
            m2_uy_reg   <= m1_uy_reg;
            m2_f1_reg   <= m1_f1_reg;
            m2_f2_reg   <= m1_f2_reg;
            m2_sx_reg   <= 34'(rnd_shift(68'(m1_px_reg), 31));
            m2_sy_reg   <= 34'(rnd_shift(68'(m1_py_reg), 31));
            m2_sum1_reg <= 65'(m1_a1_reg) + 65'(m1_b1_reg);
            m2_sum2_reg <= 65'(m1_a2_reg) + 65'(m1_b2_reg);

            m3_ux_reg   <= m2_ux_reg;
            m3_uy_reg   <= m2_uy_reg;
            m3_f1_reg   <= m2_f1_reg;
            m3_f2_reg   <= m2_f2_reg;
            m3_np1x_reg <= 35'(m_ctx_reg[2].item.first_pos_x) - 35'(m2_sx_reg);
            m3_np1y_reg <= 35'(m_ctx_reg[2].item.first_pos_y) - 35'(m2_sy_reg);
            m3_np2x_reg <= 35'(m_ctx_reg[2].item.second_pos_x) + 35'(m2_sx_reg);
            m3_np2y_reg <= 35'(m_ctx_reg[2].item.second_pos_y) + 35'(m2_sy_reg);
            m3_n1_reg   <= 35'(rnd_shift(68'(m2_sum1_reg), 30));
            m3_n2_reg   <= 35'(rnd_shift(68'(m2_sum2_reg), 30));

            m4_ux_reg    <= m3_ux_reg;
            m4_uy_reg    <= m3_uy_reg;
            m4_f1_reg    <= m3_f1_reg;
            m4_f2_reg    <= m3_f2_reg;
            m4_np1x_reg  <= m3_np1x_reg;
            m4_np1y_reg  <= m3_np1y_reg;
            m4_np2x_reg  <= m3_np2x_reg;
            m4_np2y_reg  <= m3_np2y_reg;
            m4_diff_reg  <= 36'(m3_n2_reg) - 36'(m3_n1_reg);
            m4_diffn_reg <= 36'(m3_n1_reg) - 36'(m3_n2_reg);

            m5_ux_reg   <= m4_ux_reg;
            m5_uy_reg   <= m4_uy_reg;
            m5_np1x_reg <= m4_np1x_reg;
            m5_np1y_reg <= m4_np1y_reg;
            m5_np2x_reg <= m4_np2x_reg;
            m5_np2y_reg <= m4_np2y_reg;
            m5_pr1_reg  <= m4_diff_reg * $signed({1'b0, m4_f1_reg});
            m5_pr2_reg  <= m4_diffn_reg * $signed({1'b0, m4_f2_reg});

            m6_ux_reg   <= m5_ux_reg;
            m6_uy_reg   <= m5_uy_reg;
            m6_np1x_reg <= m5_np1x_reg;
            m6_np1y_reg <= m5_np1y_reg;
            m6_np2x_reg <= m5_np2x_reg;
            m6_np2y_reg <= m5_np2y_reg;
            m6_d1_reg   <= d1_next;
            m6_d2_reg   <= d2_next;

            m7_np1x_reg <= m6_np1x_reg;
            m7_np1y_reg <= m6_np1y_reg;
            m7_np2x_reg <= m6_np2x_reg;
            m7_np2y_reg <= m6_np2y_reg;
            m7_q1x_reg  <= m6_ux_reg * m6_d1_reg;
            m7_q1y_reg  <= m6_uy_reg * m6_d1_reg;
            m7_q2x_reg  <= m6_ux_reg * m6_d2_reg;
            m7_q2y_reg  <= m6_uy_reg * m6_d2_reg;

            // coincident centres pass everything; two zero masses pass velocities
            out_data_reg.touching <= m_ctx_reg[7].touching;
            if (m_ctx_reg[7].coinc)
            begin
                out_data_reg.out_first_pos_x  <= m_ctx_reg[7].item.first_pos_x;
                out_data_reg.out_first_pos_y  <= m_ctx_reg[7].item.first_pos_y;
                out_data_reg.out_second_pos_x <= m_ctx_reg[7].item.second_pos_x;
                out_data_reg.out_second_pos_y <= m_ctx_reg[7].item.second_pos_y;
            end
            else
            begin
                out_data_reg.out_first_pos_x  <= sat32(68'(m7_np1x_reg));
                out_data_reg.out_first_pos_y  <= sat32(68'(m7_np1y_reg));
                out_data_reg.out_second_pos_x <= sat32(68'(m7_np2x_reg));
                out_data_reg.out_second_pos_y <= sat32(68'(m7_np2y_reg));
            end
            if (m_ctx_reg[7].coinc || m_ctx_reg[7].massless)
            begin
                out_data_reg.out_first_vel_x  <= m_ctx_reg[7].item.first_vel_x;
                out_data_reg.out_first_vel_y  <= m_ctx_reg[7].item.first_vel_y;
                out_data_reg.out_second_vel_x <= m_ctx_reg[7].item.second_vel_x;
                out_data_reg.out_second_vel_y <= m_ctx_reg[7].item.second_vel_y;
            end
            else
            begin
                out_data_reg.out_first_vel_x  <= sat32(68'(m_ctx_reg[7].item.first_vel_x)
                                                 + rnd_shift(m7_q1x_reg, 30));
                out_data_reg.out_first_vel_y  <= sat32(68'(m_ctx_reg[7].item.first_vel_y)
                                                 + rnd_shift(m7_q1y_reg, 30));
                out_data_reg.out_second_vel_x <= sat32(68'(m_ctx_reg[7].item.second_vel_x)
                                                 + rnd_shift(m7_q2x_reg, 30));
                out_data_reg.out_second_vel_y <= sat32(68'(m_ctx_reg[7].item.second_vel_y)
                                                 + rnd_shift(m7_q2y_reg, 30));
            end
        end
    end

endmodule

// ===== src/disc_pair_collision_response_unit.sv =====
// Top level of the disc pair collision unit: restitution register, front, queue, back.
// Depends on dpcr_pkg, dpcr_front, dpcr_queue, dpcr_back.
//
// Takes one disc pair per beat and returns one result beat per pair, in order. A new pair
// is taken every cycle while pair_ready is high. A pair passes the front stages, the queue
// and the back end (34 square root stages, 32 divider stages, 8 response stages). The
// queue (QUEUE_DEPTH entries) lets the front keep accepting while the result side stalls;
// pair_ready drops once the queue is full and the front's output stage holds a pair.
// Restitution, written with restitution_we, applies to pairs reaching the dividers after it.
module disc_pair_collision_response_unit import dpcr_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        restitution_we,
    input  logic [15:0] restitution_wdata,
    input  logic        pair_valid,
    output logic        pair_ready,
    input  in_t         pair_data,
    output logic        resp_valid,
    input  logic        resp_ready,
    output out_t        resp_data
);

    logic [15:0] restitution_reg;
    logic        push_valid, push_ready, pop_valid, pop_ready;
    cls_t        push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= RESTITUTION_RESET;
        end
        else if (restitution_we)
        begin
            restitution_reg <= restitution_wdata;
        end
    end

    dpcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair_data  (pair_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dpcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    dpcr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .restitution (restitution_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .resp_valid  (resp_valid),
        .resp_ready  (resp_ready),
        .resp_data   (resp_data)
    );

endmodule

// ===== src/dpcr_checker.sv =====
// Port-level checks for the disc pair collision unit, bound to the top level.
// Depends on dpcr_pkg and disc_pair_collision_response_unit.
module dpcr_checker import dpcr_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input logic clk,
    input logic rst_n,
    input logic pair_valid,
    input logic pair_ready,
    input logic resp_valid,
    input logic resp_ready,
    input out_t resp_data
);

    // every pipeline slot full: front, queue, back
    localparam int CAP = 3 + QUEUE_DEPTH + SQRT_STEPS + 1 + DIV_STEPS + 1 + 8;
    localparam int CW  = $clog2(CAP + 2);

    logic [CW-1:0] outstanding_reg;
    logic          in_beat, out_beat;

    assign in_beat  = pair_valid && pair_ready;
    assign out_beat = resp_valid && resp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + CW'(in_beat) - CW'(out_beat);
        end
    end

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |-> outstanding_reg != '0)
        else $error("result beat with no pair in flight");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= CW'(CAP))
        else $error("more pairs in flight than pipeline slots");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == CW'(CAP) |-> !pair_ready)
        else $error("pair accepted with every slot full");

    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid && $stable(resp_data))
        else $error("stalled result beat changed");

endmodule

bind disc_pair_collision_response_unit dpcr_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp_data  (resp_data)
);

// ===== bench/disc_pair_collision_response_unit_tb.sv =====
// Self-checking bench for disc_pair_collision_response_unit: random and directed disc pairs,
// a bit-exact collision predictor, in-order checking. Depends on dpcr_pkg and the RTL.
`timescale 1ns / 1ps

module disc_pair_collision_response_unit_tb;
    import dpcr_pkg::*;

    localparam int LATENCY   = 120;
    localparam int CYC_LIMIT = 900000;

    logic        clk;
    logic        rst_n;
    logic        restitution_we;
    logic [15:0] restitution_wdata;
    logic        pair_valid;
    logic        pair_ready;
    in_t         pair_data;
    logic        resp_valid;
    logic        resp_ready;
    out_t        resp_data;

    disc_pair_collision_response_unit DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .restitution_we    (restitution_we),
        .restitution_wdata (restitution_wdata),
        .pair_valid        (pair_valid),
        .pair_ready        (pair_ready),
        .pair_data         (pair_data),
        .resp_valid        (resp_valid),
        .resp_ready        (resp_ready),
        .resp_data         (resp_data)
    );

    in_t          pending_pairs[$];
    out_t         expected_resp[$];
    logic [15:0]  coeff_e;
    int           idle_pct;
    int           stall_pct;
    bit           hold_off;
    int           hold_cnt;
    int           mismatches;
    int           pairs_sent;
    int           resp_seen;
    int           touch_seen;
    longint       cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] abs64(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    // round to nearest, ties away, of +-m / 2^sh
    function automatic logic signed [63:0] shift_round(input bit neg, input logic [63:0] m,
                                                       input int sh);
        logic [63:0] r;
        r = (m >> sh) + ((m >> (sh - 1)) & 64'd1);
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] prod_round(input logic signed [63:0] a,
                                                      input logic signed [63:0] b, input int sh);
        logic [63:0] p;
        p = abs64(a) * abs64(b);
        return shift_round(a[63] != b[63], p, sh);
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [63:0] clip_dv(input logic signed [63:0] x);
        if (x > 64'sd17179869183)
            return 64'sd17179869183;
        if (x < -64'sd17179869183)
            return -64'sd17179869183;
        return x;
    endfunction

    function automatic out_t collide(input in_t p, input logic [15:0] e);
        logic signed [63:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
        logic signed [63:0] dx, dy, ux, uy, corr, sx, sy, sum, n1, n2, f1, f2, diff, d1, d2;
        logic [63:0]        ax, ay, rsum, m1, m2, msum, numr, root_d;
        logic [127:0]       ssq, cand;
        out_t               o;
        p1x = p.first_pos_x;  p1y = p.first_pos_y;
        v1x = p.first_vel_x;  v1y = p.first_vel_y;
        p2x = p.second_pos_x; p2y = p.second_pos_y;
        v2x = p.second_vel_x; v2y = p.second_vel_y;
        m1 = p.first_mass;
        m2 = p.second_mass;
        dx = p2x - p1x;
        dy = p2y - p1y;
        ax = abs64(dx);
        ay = abs64(dy);
        ssq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        rsum = 64'(p.first_radius) + 64'(p.second_radius);
        o.touching = (ssq <= 128'(rsum) * 128'(rsum));
        if (ssq != 0)
        begin
            root_d = 0;
            for (int b = 32; b >= 0; b--)
            begin
                cand = 128'(root_d | (64'd1 << b));
                if (cand * cand <= ssq)
                    root_d = root_d | (64'd1 << b);
            end
            ux = (ax << 30) / root_d;
            uy = (ay << 30) / root_d;
            if (dx < 0)
                ux = -ux;
            if (dy < 0)
                uy = -uy;
            corr = $signed(rsum) - $signed(root_d);
            sx = prod_round(ux, corr, 31);
            sy = prod_round(uy, corr, 31);
            p1x -= sx; p1y -= sy;
            p2x += sx; p2y += sy;
            sum = v1x * ux + v1y * uy;
            n1 = shift_round(sum < 0, abs64(sum), 30);
            sum = v2x * ux + v2y * uy;
            n2 = shift_round(sum < 0, abs64(sum), 30);
            msum = m1 + m2;
            if (msum != 0)
            begin
                numr = 64'd32768 + 64'(e);
                f1 = ((m2 * numr) << 14) / msum;
                f2 = ((m1 * numr) << 14) / msum;
                diff = n2 - n1;
                d1 = clip_dv(prod_round(diff, f1, 29));
                d2 = clip_dv(prod_round(-diff, f2, 29));
                v1x += prod_round(ux, d1, 30);
                v1y += prod_round(uy, d1, 30);
                v2x += prod_round(ux, d2, 30);
                v2y += prod_round(uy, d2, 30);
            end
        end
        o.out_first_pos_x  = clip32(p1x);
        o.out_first_pos_y  = clip32(p1y);
        o.out_first_vel_x  = clip32(v1x);
        o.out_first_vel_y  = clip32(v1y);
        o.out_second_pos_x = clip32(p2x);
        o.out_second_pos_y = clip32(p2y);
        o.out_second_vel_x = clip32(v2x);
        o.out_second_vel_y = clip32(v2y);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH beat %0d %s: got %h expected %h", resp_seen, what, got, want);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF - $urandom_range(0, 3);
            1: return 32'h80000000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 8) << 16;
            3: return -($urandom_range(0, 8) << 16);
            default: return $urandom;
        endcase
    endfunction

    // mostly overlapping pairs of sensible size, with noise of full-range fields
    function automatic in_t rand_pair();
        in_t p;
        int  kind;
        kind = $urandom_range(0, 9);
        p.first_pos_x   = $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
        p.first_pos_y   = $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
        p.first_vel_x   = $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
        p.first_vel_y   = $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
        p.first_radius  = $urandom_range(0, 32'h00100000);
        p.first_mass    = $urandom;
        p.second_radius = $urandom_range(0, 32'h00100000);
        p.second_mass   = $urandom;
        p.second_pos_x  = p.first_pos_x + $signed($urandom_range(0, 32'h00300000))
                          - 32'sh00180000;
        p.second_pos_y  = p.first_pos_y + $signed($urandom_range(0, 32'h00300000))
                          - 32'sh00180000;
        p.second_vel_x  = $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
        p.second_vel_y  = $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
        if (kind >= 7)
        begin
            p.first_pos_x   = rand_word();
            p.first_pos_y   = rand_word();
            p.first_vel_x   = rand_word();
            p.first_vel_y   = rand_word();
            p.second_pos_x  = rand_word();
            p.second_pos_y  = rand_word();
            p.second_vel_x  = rand_word();
            p.second_vel_y  = rand_word();
            p.first_radius  = $urandom;
            p.second_radius = $urandom;
        end
        if (kind == 6)
        begin
            p.first_mass  = 0;
            p.second_mass = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
        end
        if (kind == 5 && $urandom_range(0, 3) == 0)
        begin
            p.second_pos_x = p.first_pos_x;
            p.second_pos_y = p.first_pos_y;
        end
        return p;
    endfunction

    task automatic add_directed();
        in_t p;
        for (int k = 0; k < 22; k++)
        begin
            p = rand_pair();
            case (k)
                0:  p = '0;                                   // coincident, all zero
                1:  begin p.second_pos_x = p.first_pos_x; p.second_pos_y = p.first_pos_y; end
                2:  begin p.first_mass = 0; p.second_mass = 0; end
                3:  begin p.first_mass = 16'hFFFF; p.second_mass = 16'hFFFF; end
                4:  begin p.first_mass = 16'hFFFF; p.second_mass = 0; end
                5:  begin p.first_radius = '1; p.second_radius = '1; end
                6:  begin p.first_radius = 0; p.second_radius = 0; end
                7:  begin
                        p.first_pos_x = 32'sh80000000; p.first_pos_y = 32'sh80000000;
                        p.second_pos_x = 32'sh7FFFFFFF; p.second_pos_y = 32'sh7FFFFFFF;
                    end
                8:  begin
                        p.first_pos_x = 32'sh7FFFFFFF; p.first_pos_y = 32'sh80000000;
                        p.second_pos_x = 32'sh80000000; p.second_pos_y = 32'sh7FFFFFFF;
                    end
                9:  begin
                        p.first_vel_x = 32'sh7FFFFFFF; p.first_vel_y = 32'sh7FFFFFFF;
                        p.second_vel_x = 32'sh80000000; p.second_vel_y = 32'sh80000000;
                        p.first_mass = 1; p.second_mass = 16'hFFFF;
                    end
                10: begin
                        p.first_vel_x = 32'sh80000000; p.first_vel_y = 32'sh80000000;
                        p.second_vel_x = 32'sh7FFFFFFF; p.second_vel_y = 32'sh7FFFFFFF;
                        p.first_radius = '1; p.second_radius = '1;
                    end
                11: begin
                        // exactly touching along x
                        p.first_pos_y = 0; p.second_pos_y = 0;
                        p.first_pos_x = 0; p.second_pos_x = 32'sh00030000;
                        p.first_radius = 31'h10000; p.second_radius = 31'h20000;
                    end
                12: begin
                        p.first_pos_y = 0; p.second_pos_y = 0;
                        p.first_pos_x = 0; p.second_pos_x = 32'sh00030001;
                        p.first_radius = 31'h10000; p.second_radius = 31'h20000;
                    end
                13: begin p.second_pos_x = p.first_pos_x + 1; p.second_pos_y = p.first_pos_y; end
                default: ;
            endcase
            pending_pairs.push_back(p);
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((pending_pairs.size() != 0 || pair_valid || expected_resp.size() != 0)
               && guard < 400000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_coeff(input logic [15:0] v);
        @(posedge clk);
        restitution_we    <= 1'b1;
        restitution_wdata <= v;
        @(posedge clk);
        restitution_we    <= 1'b0;
        coeff_e = v;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid <= 1'b0;
            pair_data  <= '0;
        end
        else
        begin
            if (pair_valid && pair_ready)
            begin
                expected_resp.push_back(collide(pair_data, coeff_e));
                pairs_sent++;
            end
            if (!pair_valid || pair_ready)
            begin
                if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    pair_valid <= 1'b1;
                    pair_data  <= pending_pairs.pop_front();
                end
                else
                begin
                    pair_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_ready <= 1'b0;
        end
        else
        begin
            out_t w;
            if (resp_valid && resp_ready)
            begin
                if (expected_resp.size() == 0)
                begin
                    report_mismatch("unexpected beat", resp_data.out_first_pos_x, 32'd0);
                end
                else
                begin
                    w = expected_resp.pop_front();
                    if (resp_data.touching != w.touching)
                        report_mismatch("touching", resp_data.touching, w.touching);
                    if (resp_data.out_first_pos_x != w.out_first_pos_x)
                        report_mismatch("first_pos_x", resp_data.out_first_pos_x, w.out_first_pos_x);
                    if (resp_data.out_first_pos_y != w.out_first_pos_y)
                        report_mismatch("first_pos_y", resp_data.out_first_pos_y, w.out_first_pos_y);
                    if (resp_data.out_first_vel_x != w.out_first_vel_x)
                        report_mismatch("first_vel_x", resp_data.out_first_vel_x, w.out_first_vel_x);
                    if (resp_data.out_first_vel_y != w.out_first_vel_y)
                        report_mismatch("first_vel_y", resp_data.out_first_vel_y, w.out_first_vel_y);
                    if (resp_data.out_second_pos_x != w.out_second_pos_x)
                        report_mismatch("second_pos_x", resp_data.out_second_pos_x,
                                        w.out_second_pos_x);
                    if (resp_data.out_second_pos_y != w.out_second_pos_y)
                        report_mismatch("second_pos_y", resp_data.out_second_pos_y,
                                        w.out_second_pos_y);
                    if (resp_data.out_second_vel_x != w.out_second_vel_x)
                        report_mismatch("second_vel_x", resp_data.out_second_vel_x,
                                        w.out_second_vel_x);
                    if (resp_data.out_second_vel_y != w.out_second_vel_y)
                        report_mismatch("second_vel_y", resp_data.out_second_vel_y,
                                        w.out_second_vel_y);
                    if (w.touching)
                        touch_seen++;
                end
                resp_seen++;
            end
            if (hold_off)
                resp_ready <= 1'b0;
            else
                resp_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            hold_off <= 1'b1;
        end
        else
        begin
            hold_off <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("disc_pair_collision_response_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] coeffs[5];
        rst_n             = 1'b0;
        restitution_we    = 1'b0;
        restitution_wdata = '0;
        idle_pct          = 0;
        stall_pct         = 0;
        hold_off          = 1'b0;
        hold_cnt          = 0;
        mismatches        = 0;
        pairs_sent        = 0;
        resp_seen         = 0;
        touch_seen        = 0;
        cycles            = 0;
        coeff_e           = RESTITUTION_RESET;
        coeffs = '{16'd0, 16'd32768, 16'hFFFF, 16'd16384, 16'd0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the coefficient first
        add_directed();
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            coeffs[4] = $urandom_range(1, 32767);
            write_coeff(coeffs[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            if (ph == 0)
                add_directed();
            for (int k = 0; k < 370; k++)
                pending_pairs.push_back(rand_pair());
            if (ph == 3)
            begin
                // back-pressure: block fills while the sender keeps offering
                @(posedge clk);
                hold_cnt <= 300;
            end
            wait_drained();
        end

        $display("%0d pairs sent, %0d results checked, %0d touching, 6 coefficient settings",
                 pairs_sent, resp_seen, touch_seen);
        if (mismatches == 0)
            $display("disc_pair_collision_response_unit verification clean");
        else
            $display("disc_pair_collision_response_unit verification failed");
        $finish;
    end

endmodule
